// ===== src/lcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// lcsg_pkg
// Shared types, register codes and the cosine table function of the chirp
// sample generator.
// ----------------------------------------------------------------------------
package lcsg_pkg;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned INDEX_BITS     = 31;
  localparam int unsigned DAC_BITS       = 12;
  localparam int unsigned AMP_BITS       = 11;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_PTR_BITS = 2;
  localparam int unsigned QUEUE_CNT_BITS = 3;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_START_PHASE   = 3'd0,
    REG_START_STEP    = 3'd1,
    REG_STEP_CHANGE   = 3'd2,
    REG_PULSE_SAMPLES = 3'd3,
    REG_TOTAL_SAMPLES = 3'd4,
    REG_AMPLITUDE     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]          start_phase;
    logic [31:0]          start_step;
    logic [31:0]          step_change;
    logic [23:0]          pulse_samples;
    logic [30:0]          total_samples;
    logic [AMP_BITS-1:0]  amplitude;
  } cfg_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] sample_index;
    logic                  first;
    logic                  last;
    logic                  negate;
    logic                  zero;
  } meta_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Quarter-wave cosine entry: Taylor series in Q30, each term truncated.
  function automatic logic [15:0] cos_rom_entry(int unsigned k, int unsigned tab_bits,
                                                int unsigned mag_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] mag;
    logic [63:0] magmax;
    longint      sum;
    magmax = (64'd1 << mag_bits) - 64'd1;
    x      = (HALF_PI_Q30 * 64'(k)) >> tab_bits;
    x2     = (x * x) >> 30;
    term   = 64'd1 << 30;
    sum    = longint'(term);
    for (int n = 1; n < 10; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = (64'(sum) * magmax) >> 30;
    if (mag > magmax) begin
      mag = magmax;
    end
    return mag[15:0];
  endfunction

endpackage

// ===== src/linear_chirp_sample_generator_unit.sv =====
// ----------------------------------------------------------------------------
// linear_chirp_sample_generator_unit
// Linear FM chirp sample generator: amplitude times cosine of a quadratic
// phase built by double accumulation.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i
//   while the block is idle. Each input transaction carries restart_i:
//   1 rewinds the waveform and produces no sample, 0 requests the next
//   sample. Requests after the last sample of a waveform produce nothing.
//   Throughput is one sample per clock while in_stall_o is low; the phase
//   and step adds feed registered accumulators, and the table read, amplitude
//   multiply and scaling multiply are pipelined behind a four-entry queue.
//   A request passes the queue, table, product, quotient and output registers.
//   When the receiver stalls, the back pipeline holds and the queue fills;
//   in_stall_o rises once the queue is full.
//   Reset restores register defaults, clears accumulators and counters and
//   leaves the generator finished until a restart is accepted.
// ----------------------------------------------------------------------------
module linear_chirp_sample_generator_unit #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_MAG_BITS = 11
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [lcsg_pkg::CFG_INDEX_BITS-1:0]       cfg_index_i,
  input  logic [lcsg_pkg::CFG_DATA_BITS-1:0]        cfg_data_i,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic                                      restart_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic [lcsg_pkg::INDEX_BITS-1:0]           sample_index_o,
  output logic signed [lcsg_pkg::DAC_BITS-1:0]      dac_value_o,
  output logic                                      pulse_first_o,
  output logic                                      last_o
);
  import lcsg_pkg::*;

  localparam int unsigned QW = $bits(meta_t) + TABLE_ADDR_BITS;

  cfg_t                         cfg_q;
  logic                         q_push, q_pop;
  meta_t                        f_meta, b_meta;
  logic [TABLE_ADDR_BITS-1:0]   f_addr, b_addr;
  logic [QW-1:0]                q_rd;
  q_status_t                    q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_phase   <= '0;
      cfg_q.start_step    <= '0;
      cfg_q.step_change   <= '0;
      cfg_q.pulse_samples <= 24'd1;
      cfg_q.total_samples <= 31'd1;
      cfg_q.amplitude     <= 11'd2047;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_START_PHASE:   cfg_q.start_phase   <= cfg_data_i;
        REG_START_STEP:    cfg_q.start_step    <= cfg_data_i;
        REG_STEP_CHANGE:   cfg_q.step_change   <= cfg_data_i;
        REG_PULSE_SAMPLES: cfg_q.pulse_samples <= cfg_data_i[23:0];
        REG_TOTAL_SAMPLES: cfg_q.total_samples <= cfg_data_i[30:0];
        REG_AMPLITUDE:     cfg_q.amplitude     <= cfg_data_i[AMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_stat.full;

  lcsg_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .full_i     (q_stat.full),
    .push_o     (q_push),
    .meta_o     (f_meta),
    .addr_o     (f_addr)
  );

  lcsg_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   ({f_meta, f_addr}),
    .pop_i    (q_pop),
    .data_o   (q_rd),
    .status_o (q_stat)
  );

  assign {b_meta, b_addr} = q_rd;

  lcsg_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_MAG_BITS (SAMPLE_MAG_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .amplitude_i    (cfg_q.amplitude),
    .q_empty_i      (q_stat.empty),
    .q_meta_i       (b_meta),
    .q_addr_i       (b_addr),
    .pop_o          (q_pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .sample_index_o (sample_index_o),
    .dac_value_o    (dac_value_o),
    .pulse_first_o  (pulse_first_o),
    .last_o         (last_o)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_stat.full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_stat.empty))
    else $error("queue pop while empty");

  a_full_after_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.full && !q_pop) |=> q_stat.full)
    else $error("queue full flag dropped without a pop");
`endif

endmodule

// ===== src/lcsg_queue.sv =====
// ----------------------------------------------------------------------------
// lcsg_queue
// Short register queue between the phase front end and the sample back end.
// ----------------------------------------------------------------------------
module lcsg_queue #(
  parameter int unsigned WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [WIDTH-1:0]      data_i,
  input  logic                  pop_i,
  output logic [WIDTH-1:0]      data_o,
  output lcsg_pkg::q_status_t   status_o
);
  import lcsg_pkg::*;

  logic [WIDTH-1:0]          mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_BITS-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

// ===== src/lcsg_front.sv =====
// ----------------------------------------------------------------------------
// lcsg_front
// Accepts requests, runs the phase and step accumulators and the pulse and
// waveform counters, and queues table address and flags per sample.
// ----------------------------------------------------------------------------
module lcsg_front #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lcsg_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  input  logic                        restart_i,
  input  logic                        full_i,
  output logic                        push_o,
  output lcsg_pkg::meta_t             meta_o,
  output logic [TABLE_ADDR_BITS-1:0]  addr_o
);
  import lcsg_pkg::*;

  localparam int unsigned PB  = PHASE_BITS;
  localparam int unsigned TAB = TABLE_ADDR_BITS;

  logic [PB+31:0]          sp_ext, ss_ext, sc_ext;
  logic [PB-1:0]           start_phase_w, start_step_w, step_change_w;
  logic [PB-1:0]           phase_q, phase_d, step_q, step_d;
  logic [PB-1:0]           phase_cur, step_cur;
  logic [23:0]             pos_q, pos_d, pos_inc, ps;
  logic [INDEX_BITS-1:0]   cnt_q, cnt_d, ts;
  logic [INDEX_BITS:0]     cnt_inc;
  logic                    fin_q, fin_d;
  logic                    accept, first, last;
  logic [1:0]              quad;
  logic [TAB-1:0]          idx;

  // 32-bit words sit at the top of the accumulator width
  assign sp_ext        = {cfg_i.start_phase, {PB{1'b0}}};
  assign ss_ext        = {cfg_i.start_step, {PB{1'b0}}};
  assign sc_ext        = {cfg_i.step_change, {PB{1'b0}}};
  assign start_phase_w = sp_ext[PB+31:32];
  assign start_step_w  = ss_ext[PB+31:32];
  assign step_change_w = sc_ext[PB+31:32];

  assign ps = (cfg_i.pulse_samples == '0) ? 24'd1 : cfg_i.pulse_samples;
  assign ts = (cfg_i.total_samples == '0) ? INDEX_BITS'(1) : cfg_i.total_samples;

  assign accept    = in_valid_i && !full_i;
  assign first     = (pos_q == '0);
  assign phase_cur = first ? start_phase_w : phase_q;
  assign step_cur  = first ? start_step_w : step_q;
  assign cnt_inc   = {1'b0, cnt_q} + (INDEX_BITS+1)'(1);
  assign last      = (cnt_inc >= {1'b0, ts});
  assign pos_inc   = pos_q + 24'd1;

  assign quad = phase_cur[PB-1:PB-2];
  assign idx  = phase_cur[PB-3 -: TAB];

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    push_o  = 1'b0;
    if (accept) begin
      if (restart_i) begin
        pos_d = '0;
        cnt_d = '0;
        fin_d = 1'b0;
      end else if (!fin_q) begin
        push_o  = 1'b1;
        phase_d = phase_cur + step_cur;
        step_d  = step_cur + step_change_w;
        pos_d   = ((pos_inc >= ps) || (pos_inc == '0)) ? 24'd0 : pos_inc;
        cnt_d   = cnt_inc[INDEX_BITS-1:0];
        if (last) begin
          fin_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    meta_o.sample_index = cnt_q;
    meta_o.first        = first;
    meta_o.last         = last;
    meta_o.negate       = quad[1] ^ quad[0];
    meta_o.zero         = quad[0] && (idx == '0);
    addr_o              = quad[0] ? (TAB'(0) - idx) : idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      fin_q   <= 1'b1;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
    end
  end

endmodule

// ===== src/lcsg_back.sv =====
// ----------------------------------------------------------------------------
// lcsg_back
// Cosine table lookup, amplitude scaling and output register, pipelined
// under one advance enable driven by the output stall.
// ----------------------------------------------------------------------------
module lcsg_back #(
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_MAG_BITS = 11
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [lcsg_pkg::AMP_BITS-1:0]         amplitude_i,
  input  logic                                  q_empty_i,
  input  lcsg_pkg::meta_t                       q_meta_i,
  input  logic [TABLE_ADDR_BITS-1:0]            q_addr_i,
  output logic                                  pop_o,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic [lcsg_pkg::INDEX_BITS-1:0]       sample_index_o,
  output logic signed [lcsg_pkg::DAC_BITS-1:0]  dac_value_o,
  output logic                                  pulse_first_o,
  output logic                                  last_o
);
  import lcsg_pkg::*;

  localparam int unsigned TAB     = TABLE_ADDR_BITS;
  localparam int unsigned MB      = SAMPLE_MAG_BITS;
  localparam int unsigned QSIZE   = 1 << TAB;
  localparam int unsigned PROD_W  = AMP_BITS + MB;
  localparam int unsigned RECIP_W = PROD_W + 1;
  localparam int unsigned SHIFT   = PROD_W + MB;
  localparam logic [63:0] MAGMAX  = (64'd1 << MB) - 64'd1;
  localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + MAGMAX - 64'd1) / MAGMAX;
  localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];

  logic [MB-1:0]               rom_mem [QSIZE];
  logic                        adv;
  logic                        v1_q, v2_q, v3_q, out_valid_q;
  meta_t                       m1_q, m2_q, m3_q;
  logic [MB-1:0]               rom_q;
  logic [MB-1:0]               mag;
  logic [PROD_W-1:0]           prod_q;
  logic [PROD_W+RECIP_W-1:0]   scaled;
  logic [AMP_BITS-1:0]         quo_q;
  logic [DAC_BITS-1:0]         quo_ext;
  logic [INDEX_BITS-1:0]       idx_out_q;
  logic [DAC_BITS-1:0]         dac_q;
  logic                        first_q, last_q;

  for (genvar k = 0; k < QSIZE; k++) begin : g_rom
    localparam logic [15:0] ENTRY = cos_rom_entry(k, TAB, MB);
    assign rom_mem[k] = ENTRY[MB-1:0];
  end

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !q_empty_i;

  assign mag     = m1_q.zero ? '0 : rom_q;
  assign scaled  = prod_q * RECIP;
  assign quo_ext = {1'b0, quo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= !q_empty_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rom_q     <= rom_mem[q_addr_i];
      m1_q      <= q_meta_i;
      prod_q    <= amplitude_i * mag;
      m2_q      <= m1_q;
      quo_q     <= scaled[SHIFT +: AMP_BITS];
      m3_q      <= m2_q;
      idx_out_q <= m3_q.sample_index;
      first_q   <= m3_q.first;
      last_q    <= m3_q.last;
      dac_q     <= m3_q.negate ? (DAC_BITS'(0) - quo_ext) : quo_ext;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_index_o = idx_out_q;
  assign dac_value_o    = $signed(dac_q);
  assign pulse_first_o  = first_q;
  assign last_o         = last_q;

endmodule
